[design/video_id_base58_codec_macros.svh]
// assertion macros shared by the video id codec rtl
`ifndef VIDEO_ID_BASE58_CODEC_MACROS_SVH
`define VIDEO_ID_BASE58_CODEC_MACROS_SVH

// checked at every clock edge outside reset
`define VIDB58_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define VIDB58_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/vidb58_pkg.sv]
// types, constants and alphabet functions for the base-58 video id codec
`default_nettype none

package vidb58_pkg;

	localparam int unsigned RADIX = 58;
	localparam int unsigned NUM_SLOTS = 6;

	// 58^2 and 58^3
	localparam int unsigned RADIX_SQ = 3364;
	localparam int unsigned RADIX_CUBE = 195112;

	localparam logic [34:0] XOR_KEY = 35'h00A93B324;
	localparam logic [34:0] ADD_OFFSET = 35'd8728348608;

	// floor(2^32 / 24389), 24389 = 58^3 / 8, quotient estimate is low by at most one
	localparam logic [17:0] RECIP_CUBE = 18'd176102;
	// ceil(2^24 / 58) and ceil(2^30 / 3364), exact for values below 58^3
	localparam logic [18:0] RECIP_RADIX = 19'd289263;
	localparam int unsigned RECIP_RADIX_SHIFT = 24;
	localparam logic [18:0] RECIP_RADIX_SQ = 19'd319187;
	localparam int unsigned RECIP_RADIX_SQ_SHIFT = 30;

	localparam logic [RADIX*8-1:0] ALPHABET =
		"fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef struct packed {
		logic        operation;
		logic [33:0] id_number;
		logic [7:0]  char_slot0;
		logic [7:0]  char_slot1;
		logic [7:0]  char_slot2;
		logic [7:0]  char_slot3;
		logic [7:0]  char_slot4;
		logic [7:0]  char_slot5;
	} codec_req_t;

	typedef struct packed {
		logic [34:0] out_number;
		logic [7:0]  out_slot0;
		logic [7:0]  out_slot1;
		logic [7:0]  out_slot2;
		logic [7:0]  out_slot3;
		logic [7:0]  out_slot4;
		logic [7:0]  out_slot5;
		logic        error_flag;
	} codec_rsp_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} digit_t;

	// first letter of the string sits in the top byte
	function automatic logic [7:0] letter_of(input logic [5:0] d);
		logic [7:0] c;
		c = '0;
		if (int'(d) < RADIX)
			c = ALPHABET[(RADIX - 1 - int'(d)) * 8 +: 8];
		return c;
	endfunction

	function automatic digit_t digit_of(input logic [7:0] code);
		digit_t r;
		r = '0;
		for (int k = 0; k < RADIX; k++) begin
			if (ALPHABET[(RADIX - 1 - k) * 8 +: 8] == code) begin
				r.ok = 1'b1;
				r.value = 6'(k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/video_id_base58_codec.sv]
// two-way converter between a numeric video id and its six base-58 characters
`default_nettype none
`include "video_id_base58_codec_macros.svh"

// Takes one item in every clock cycle (busy stays low) and returns its result once
// the item has passed the six register stages of the pipeline: done is high for one
// cycle with the result on the result port, and the receiver cannot hold it off. The
// stages are the input register, then the reciprocal multiplies that split the value
// into two base-58^3 halves and then into digits, then the result register. Encode
// gives the six characters with number and error at zero; decode gives the number with
// the characters at zero, or error with a zero number when a character is outside the
// alphabet or the sum is below offset.
module video_id_base58_codec (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire vidb58_pkg::codec_req_t  request,
	output logic                         done,
	output vidb58_pkg::codec_rsp_t       result
);
	import vidb58_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic accept;

	codec_req_t req_s1;

	logic        op_s2, op_s3, op_s4, op_s5;
	logic [34:0] x_s2, x_s3;
	digit_t      dig_s2 [NUM_SLOTS];

	logic [17:0] qe_s3;
	logic [17:0] lo_d_s3, hi_d_s3;
	logic        bad_s3, bad_s4;

	logic [17:0] half_s4 [2];
	logic [35:0] sum_s4;

	logic [17:0] half_s5 [2];
	logic [11:0] q1_s5 [2];
	logic [5:0]  q2_s5 [2];
	logic [34:0] num_s5;
	logic        bad_s5;

	codec_rsp_t rsp_s6;

	// stage combinational signals
	logic [7:0]  chars [NUM_SLOTS];
	logic [49:0] qe_prod;
	logic [35:0] rem_full;
	logic [35:0] qe_times;
	logic [36:0] q1_prod [2];
	logic [36:0] q2_prod [2];
	logic [35:0] diff;
	logic [17:0] d0_full [2];
	logic [17:0] d1_full [2];
	logic [5:0]  digit [NUM_SLOTS];
	codec_rsp_t  rsp_next;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign chars[0] = req_s1.char_slot0;
	assign chars[1] = req_s1.char_slot1;
	assign chars[2] = req_s1.char_slot2;
	assign chars[3] = req_s1.char_slot3;
	assign chars[4] = req_s1.char_slot4;
	assign chars[5] = req_s1.char_slot5;

	always_comb begin
		qe_prod = 50'(x_s2[34:3]) * 50'(RECIP_CUBE);
		qe_times = 36'(qe_s3) * 36'(RADIX_CUBE);
		rem_full = {1'b0, x_s3} - qe_times;
		diff = sum_s4 - 36'(ADD_OFFSET);
		for (int h = 0; h < 2; h++) begin
			q1_prod[h] = 37'(half_s4[h]) * 37'(RECIP_RADIX);
			q2_prod[h] = 37'(half_s4[h]) * 37'(RECIP_RADIX_SQ);
			d0_full[h] = half_s5[h] - 18'(q1_s5[h]) * 18'(RADIX);
			d1_full[h] = 18'(q1_s5[h]) - 18'(q2_s5[h]) * 18'(RADIX);
			digit[3 * h] = d0_full[h][5:0];
			digit[3 * h + 1] = d1_full[h][5:0];
			digit[3 * h + 2] = q2_s5[h];
		end
	end

	always_comb begin
		rsp_next = '0;
		if (op_s5 == OP_ENCODE) begin
			rsp_next.out_slot0 = letter_of(digit[0]);
			rsp_next.out_slot1 = letter_of(digit[1]);
			rsp_next.out_slot2 = letter_of(digit[2]);
			rsp_next.out_slot3 = letter_of(digit[3]);
			rsp_next.out_slot4 = letter_of(digit[4]);
			rsp_next.out_slot5 = letter_of(digit[5]);
		end else begin
			rsp_next.out_number = num_s5;
			rsp_next.error_flag = bad_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= request;

		// s2: offset the id, look the characters up
		op_s2 <= req_s1.operation;
		x_s2 <= (35'(req_s1.id_number) ^ XOR_KEY) + ADD_OFFSET;
		for (int k = 0; k < NUM_SLOTS; k++)
			dig_s2[k] <= digit_of(chars[k]);

		// s3: estimate of x / 58^3, digits folded into two halves
		op_s3 <= op_s2;
		x_s3 <= x_s2;
		qe_s3 <= qe_prod[49:32];
		lo_d_s3 <= 18'(dig_s2[0].value) + 18'(dig_s2[1].value) * 18'(RADIX)
			+ 18'(dig_s2[2].value) * 18'(RADIX_SQ);
		hi_d_s3 <= 18'(dig_s2[3].value) + 18'(dig_s2[4].value) * 18'(RADIX)
			+ 18'(dig_s2[5].value) * 18'(RADIX_SQ);
		bad_s3 <= !(dig_s2[0].ok && dig_s2[1].ok && dig_s2[2].ok
			&& dig_s2[3].ok && dig_s2[4].ok && dig_s2[5].ok);

		// s4: correct the quotient estimate, recombine the decode sum
		op_s4 <= op_s3;
		bad_s4 <= bad_s3;
		if (rem_full >= 36'(RADIX_CUBE)) begin
			half_s4[0] <= 18'(rem_full - 36'(RADIX_CUBE));
			half_s4[1] <= qe_s3 + 18'd1;
		end else begin
			half_s4[0] <= rem_full[17:0];
			half_s4[1] <= qe_s3;
		end
		sum_s4 <= 36'(hi_d_s3) * 36'(RADIX_CUBE) + 36'(lo_d_s3);

		// s5: divide each half by 58 and 58^2, remove the offset
		op_s5 <= op_s4;
		for (int h = 0; h < 2; h++) begin
			half_s5[h] <= half_s4[h];
			q1_s5[h] <= q1_prod[h][RECIP_RADIX_SHIFT +: 12];
			q2_s5[h] <= q2_prod[h][RECIP_RADIX_SQ_SHIFT +: 6];
		end
		bad_s5 <= bad_s4 || (sum_s4 < 36'(ADD_OFFSET));
		if (bad_s4 || (sum_s4 < 36'(ADD_OFFSET)))
			num_s5 <= '0;
		else
			num_s5 <= diff[34:0] ^ XOR_KEY;

		// s6: result register
		rsp_s6 <= rsp_next;
	end

	assign done = v_s6;
	assign result = rsp_s6;

	`VIDB58_ASSERT(a_latency, accept |-> ##6 done, "item taken but no result six cycles later")
	`VIDB58_ASSERT(a_no_phantom, done |-> $past(accept, 6), "result without an item taken")
	`VIDB58_ASSERT(a_error_zero, done && result.error_flag |-> result.out_number == '0,
		"error result carries a nonzero number")
	`VIDB58_ASSERT(a_modes_apart, done && result.out_slot0 != '0 |->
		!result.error_flag && result.out_number == '0, "encode result mixed with decode fields")
	`VIDB58_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done, "result strobe during reset")

endmodule

`default_nettype wire

[verif/video_id_base58_codec_tb.sv]
// testbench for the base-58 video id codec: queued items, own conversion model, field checks
`timescale 1ns / 100ps

module video_id_base58_codec_tb;
	import vidb58_pkg::*;

	localparam logic [58*8-1:0] LETTERS =
		"fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";
	localparam logic [63:0] ID_KEY = 64'h0A93B324;
	localparam logic [63:0] ID_OFFSET = 64'd8728348608;
	localparam logic [63:0] ID_BASE = 64'd58;
	localparam logic [63:0] SUM_MAX = 64'd38068692543;
	localparam int RANDOM_ITEMS = 1500;

	typedef struct packed {
		logic       drain_first;
		codec_req_t req;
	} queued_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	codec_req_t request = '0;
	codec_rsp_t result;

	queued_item_t conversion_q[$];
	codec_rsp_t awaited_rsp_q[$];
	int accepted_count = 0;
	int mismatches = 0;

	video_id_base58_codec dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] letter_for(input int unsigned d);
		return LETTERS[(57 - d) * 8 +: 8];
	endfunction

	// -1 when the code is not one of the 58 letters
	function automatic int digit_for(input logic [7:0] code);
		int d;
		d = -1;
		for (int k = 0; k < 58; k++) begin
			if (LETTERS[(57 - k) * 8 +: 8] == code)
				d = k;
		end
		return d;
	endfunction

	function automatic codec_rsp_t convert_id(input codec_req_t req);
		codec_rsp_t rsp;
		logic [63:0] work;
		logic [63:0] weight;
		logic [7:0] chars [6];
		int d;
		logic bad;
		rsp = '0;
		if (req.operation == OP_ENCODE) begin
			work = ({30'b0, req.id_number} ^ ID_KEY) + ID_OFFSET;
			for (int k = 0; k < 6; k++) begin
				chars[k] = letter_for(int'(work % ID_BASE));
				work = work / ID_BASE;
			end
			rsp.out_slot0 = chars[0];
			rsp.out_slot1 = chars[1];
			rsp.out_slot2 = chars[2];
			rsp.out_slot3 = chars[3];
			rsp.out_slot4 = chars[4];
			rsp.out_slot5 = chars[5];
		end else begin
			chars[0] = req.char_slot0;
			chars[1] = req.char_slot1;
			chars[2] = req.char_slot2;
			chars[3] = req.char_slot3;
			chars[4] = req.char_slot4;
			chars[5] = req.char_slot5;
			work = '0;
			weight = 64'd1;
			bad = 1'b0;
			for (int k = 0; k < 6; k++) begin
				d = digit_for(chars[k]);
				if (d < 0)
					bad = 1'b1;
				else
					work = work + 64'(d) * weight;
				weight = weight * ID_BASE;
			end
			if (!bad && work < ID_OFFSET)
				bad = 1'b1;
			if (bad)
				rsp.error_flag = 1'b1;
			else
				rsp.out_number = 35'((work - ID_OFFSET) ^ ID_KEY);
		end
		return rsp;
	endfunction

	function automatic codec_req_t with_code(input codec_req_t r, input int k,
			input logic [7:0] c);
		case (k)
			0: r.char_slot0 = c;
			1: r.char_slot1 = c;
			2: r.char_slot2 = c;
			3: r.char_slot3 = c;
			4: r.char_slot4 = c;
			default: r.char_slot5 = c;
		endcase
		return r;
	endfunction

	// random content in the id and every character field, so unused fields toggle too
	function automatic codec_req_t junk_req(input op_t op);
		codec_req_t r;
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		r.operation = op;
		r.id_number = wide[33:0];
		r.char_slot0 = 8'($urandom);
		r.char_slot1 = 8'($urandom);
		r.char_slot2 = 8'($urandom);
		r.char_slot3 = 8'($urandom);
		r.char_slot4 = 8'($urandom);
		r.char_slot5 = 8'($urandom);
		return r;
	endfunction

	// decode item whose six characters spell the given base-58 sum
	function automatic codec_req_t spell_sum(input logic [63:0] total);
		codec_req_t r;
		r = junk_req(OP_DECODE);
		for (int k = 0; k < 6; k++) begin
			r = with_code(r, k, letter_for(int'(total % ID_BASE)));
			total = total / ID_BASE;
		end
		return r;
	endfunction

	function automatic codec_req_t encode_req(input logic [33:0] id);
		codec_req_t r;
		r = junk_req(OP_ENCODE);
		r.id_number = id;
		return r;
	endfunction

	task automatic queue_item(input codec_req_t r, input logic drain);
		queued_item_t item;
		item.drain_first = drain;
		item.req = r;
		conversion_q.push_back(item);
	endtask

	task automatic report_field(input string name, input logic [34:0] want,
			input logic [34:0] got);
		$display("%0t ns: %s mismatch, expected %h got %h", $time, name, want, got);
		mismatches++;
	endtask

	// driver: the offered item stays up until taken, then the next one from the queue
	always @(posedge clk or negedge arst_n) begin
		queued_item_t nxt;
		logic idle;
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				awaited_rsp_q.push_back(convert_id(request));
				accepted_count++;
			end
			if (!start || !busy) begin
				// no gaps at all for a stretch in the middle of the run
				idle = (accepted_count < 400 || accepted_count > 800)
					&& $urandom_range(0, 99) < 16;
				if (conversion_q.size() != 0 && !idle
						&& !(conversion_q[0].drain_first && awaited_rsp_q.size() != 0)) begin
					nxt = conversion_q.pop_front();
					request <= nxt.req;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed result against the oldest prediction
	always @(posedge clk) begin
		codec_rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_rsp_q.size() == 0) begin
				$display("%0t ns: result with none expected, got %h", $time, result);
				mismatches++;
			end else begin
				want = awaited_rsp_q.pop_front();
				if (result.out_number !== want.out_number)
					report_field("out_number", want.out_number, result.out_number);
				if (result.out_slot0 !== want.out_slot0)
					report_field("out_slot0", 35'(want.out_slot0), 35'(result.out_slot0));
				if (result.out_slot1 !== want.out_slot1)
					report_field("out_slot1", 35'(want.out_slot1), 35'(result.out_slot1));
				if (result.out_slot2 !== want.out_slot2)
					report_field("out_slot2", 35'(want.out_slot2), 35'(result.out_slot2));
				if (result.out_slot3 !== want.out_slot3)
					report_field("out_slot3", 35'(want.out_slot3), 35'(result.out_slot3));
				if (result.out_slot4 !== want.out_slot4)
					report_field("out_slot4", 35'(want.out_slot4), 35'(result.out_slot4));
				if (result.out_slot5 !== want.out_slot5)
					report_field("out_slot5", 35'(want.out_slot5), 35'(result.out_slot5));
				if (result.error_flag !== want.error_flag)
					report_field("error_flag", 35'(want.error_flag), 35'(result.error_flag));
			end
		end
	end

	initial begin
		logic [7:0] bad_codes [6];
		logic [63:0] wide;
		logic [63:0] total;
		codec_req_t r;
		int pick;

		bad_codes[0] = 8'h00;
		bad_codes[1] = 8'hFF;
		bad_codes[2] = "l";
		bad_codes[3] = "0";
		bad_codes[4] = "I";
		bad_codes[5] = "O";

		// encode extremes, and the id that lands exactly on the offset
		queue_item(encode_req(34'h0), 1'b0);
		queue_item(encode_req(34'h3FFFFFFFF), 1'b0);
		queue_item(encode_req(34'(ID_KEY)), 1'b0);
		queue_item(encode_req(34'h2AAAAAAAA), 1'b0);
		queue_item(encode_req(34'h155555555), 1'b0);
		// decode: all zero digits, just below the offset, at it, largest sum
		queue_item(spell_sum(64'd0), 1'b0);
		queue_item(spell_sum(ID_OFFSET - 64'd1), 1'b0);
		queue_item(spell_sum(ID_OFFSET), 1'b0);
		queue_item(spell_sum(SUM_MAX), 1'b0);
		queue_item(spell_sum(ID_KEY + ID_OFFSET), 1'b0);
		queue_item(spell_sum((64'h3FFFFFFFF ^ ID_KEY) + ID_OFFSET), 1'b0);
		// a character outside the alphabet in each slot
		for (int k = 0; k < 6; k++)
			queue_item(with_code(spell_sum(SUM_MAX - 64'(k)), k, bad_codes[k]), 1'b0);
		r = spell_sum(ID_OFFSET);
		for (int k = 0; k < 6; k++)
			r = with_code(r, k, 8'h00);
		queue_item(r, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			wide = {$urandom, $urandom};
			if (pick < 40) begin
				r = encode_req(wide[33:0]);
			end else if (pick < 75) begin
				total = '0;
				for (int k = 5; k >= 0; k--)
					total = total * ID_BASE + 64'($urandom_range(0, 57));
				r = spell_sum(total);
			end else if (pick < 88) begin
				r = spell_sum(({30'b0, wide[33:0]} ^ ID_KEY) + ID_OFFSET);
			end else begin
				// well-formed characters with one or two random bytes dropped in
				r = spell_sum(64'($urandom_range(0, 2147483647)) * 64'd17);
				r = with_code(r, $urandom_range(0, 5), 8'($urandom));
				if (pick > 95)
					r = with_code(r, $urandom_range(0, 5), 8'($urandom));
			end
			// for items 0 and 1000 the pipeline drains completely before the item goes in
			queue_item(r, n == 0 || n == 1000);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (conversion_q.size() != 0 || start)
			@(posedge clk);
		while (awaited_rsp_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#1000000;
		$display("timeout with %0d results outstanding", awaited_rsp_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/vidb58_pkg.sv
design/video_id_base58_codec.sv
verif/video_id_base58_codec_tb.sv
